### rtl/tea_pkg.sv
// Shared constants, codes and control types of the two-ended arena allocator.
`timescale 1ns / 1ps
`default_nettype none
package tea_pkg;

   localparam int ADDR_W  = 32;
   localparam int PTR_W   = 33;
   localparam int SIZE_W  = 25;
   localparam int ALIGN_W = 13;
   localparam int CNT_W   = 16;
   localparam int STAT_W  = 2;
   localparam int REQ_W   = 3;
   localparam int STEP_W  = 6;

   localparam logic [SIZE_W-1:0]  ARENA_MAX_BYTES = SIZE_W'(16777216);
   localparam logic [ALIGN_W-1:0] ALIGN_MAX       = ALIGN_W'(4096);
   localparam logic [STEP_W-1:0]  DIV_LAST        = STEP_W'(PTR_W - 1);

   localparam logic [REQ_W-1:0] REQ_PERSIST = 3'd0;
   localparam logic [REQ_W-1:0] REQ_TEMP    = 3'd1;
   localparam logic [REQ_W-1:0] REQ_FREE    = 3'd2;
   localparam logic [REQ_W-1:0] REQ_RESET   = 3'd3;
   localparam logic [REQ_W-1:0] REQ_RESIZE  = 3'd4;

   localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
   localparam logic [STAT_W-1:0] ST_OOM   = 2'd1;
   localparam logic [STAT_W-1:0] ST_HEAD  = 2'd2;
   localparam logic [STAT_W-1:0] ST_TEMPS = 2'd3;

   localparam logic CSR_BASE = 1'b0;
   localparam logic CSR_SIZE = 1'b1;

   typedef struct packed {
      logic capture;
      logic op_start;
      logic apply;
      logic fin_start;
      logic load;
   } tea_cmd_type;

   typedef struct packed {
      logic op_div_req;
      logic op_done;
      logic fin_done;
   } tea_sts_type;

endpackage
`default_nettype wire

### rtl/tea_if.sv
// Request and response channel interfaces of the arena allocator.
`timescale 1ns / 1ps
`default_nettype none
interface tea_req_if;
   import tea_pkg::*;
   logic                 valid;
   logic                 ready;
   logic [REQ_W-1:0]     req_type;
   logic [SIZE_W-1:0]    alloc_size;
   logic [ALIGN_W-1:0]   align;
   logic [ADDR_W-1:0]    buffer_addr;
   modport source (output valid, req_type, alloc_size, align, buffer_addr, input ready);
   modport sink   (input valid, req_type, alloc_size, align, buffer_addr, output ready);
endinterface

interface tea_rsp_if;
   import tea_pkg::*;
   logic                 valid;
   logic                 ready;
   logic [STAT_W-1:0]    status;
   logic [ADDR_W-1:0]    result_addr;
   logic [SIZE_W-1:0]    persistent_used;
   logic [SIZE_W-1:0]    nonpersistent_used;
   logic [SIZE_W-1:0]    persistent_peak;
   logic [SIZE_W-1:0]    nonpersistent_peak;
   logic [SIZE_W-1:0]    free_bytes;
   logic signed [CNT_W-1:0] temps_outstanding;
   logic                 temps_clean;
   modport source (output valid, status, result_addr, persistent_used, nonpersistent_used,
                   persistent_peak, nonpersistent_peak, free_bytes, temps_outstanding,
                   temps_clean, input ready);
   modport sink   (input valid, status, result_addr, persistent_used, nonpersistent_used,
                   persistent_peak, nonpersistent_peak, free_bytes, temps_outstanding,
                   temps_clean, output ready);
endinterface
`default_nettype wire

### rtl/tea_rem.sv
// Bit-serial remainder unit: one dividend bit per cycle against the alignment.
`timescale 1ns / 1ps
`default_nettype none
module tea_rem (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       start,
   input  wire logic [tea_pkg::PTR_W-1:0]  dividend,
   input  wire logic [tea_pkg::ALIGN_W-1:0] divisor,
   output logic                            done,
   output logic [tea_pkg::ALIGN_W-1:0]     remainder
);
   import tea_pkg::*;

   logic                 busy_ff;
   logic                 done_ff;
   logic [STEP_W-1:0]    step_ff;
   logic [PTR_W-1:0]     dvd_ff;
   logic [ALIGN_W-1:0]   dvs_ff;
   logic [ALIGN_W-1:0]   rem_ff;
   logic [ALIGN_W:0]     trial;
   logic [ALIGN_W-1:0]   rem_in;

   always_comb begin
      trial = {rem_ff, dvd_ff[PTR_W-1]};
      if (trial >= {1'b0, dvs_ff}) begin
         rem_in = ALIGN_W'(trial - {1'b0, dvs_ff});
      end else begin
         rem_in = trial[ALIGN_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            step_ff <= '0;
         end else if (busy_ff) begin
            step_ff <= step_ff + 1'b1;
            if (step_ff == DIV_LAST) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         dvd_ff <= dividend;
         dvs_ff <= divisor;
         rem_ff <= '0;
      end else if (busy_ff) begin
         dvd_ff <= {dvd_ff[PTR_W-2:0], 1'b0};
         rem_ff <= rem_in;
      end
   end

   assign done      = done_ff;
   assign remainder = rem_ff;

`ifndef NO_ASSERTIONS
   a_start_busy: assert property (@(posedge clock) disable iff (reset)
      start |=> busy_ff) else $error("remainder unit did not start");
   a_finish: assert property (@(posedge clock) disable iff (reset)
      busy_ff && !start && step_ff == DIV_LAST |=> done_ff && !busy_ff)
      else $error("remainder unit did not finish after the last step");
   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> !busy_ff) else $error("done raised while still busy");
`endif
endmodule
`default_nettype wire

### rtl/tea_ctrl.sv
// Sequencing state machine of the arena allocator.
`timescale 1ns / 1ps
`default_nettype none
module tea_ctrl (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_ready,
   output logic                      rsp_valid,
   input  wire logic                 rsp_ready,
   input  wire tea_pkg::tea_sts_type sts,
   output tea_pkg::tea_cmd_type      cmd
);
   import tea_pkg::*;

   typedef enum logic [6:0] {
      S_IDLE  = 7'b0000001,
      S_OP    = 7'b0000010,
      S_OPW   = 7'b0000100,
      S_APPLY = 7'b0001000,
      S_FIN   = 7'b0010000,
      S_FINW  = 7'b0100000,
      S_DONE  = 7'b1000000
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = S_OP;
            end
         end
         S_OP: begin
            if (sts.op_div_req) begin
               cmd.op_start = 1'b1;
               state_in     = S_OPW;
            end else begin
               state_in = S_APPLY;
            end
         end
         S_OPW: begin
            if (sts.op_done) begin
               state_in = S_APPLY;
            end
         end
         S_APPLY: begin
            cmd.apply = 1'b1;
            state_in  = S_FIN;
         end
         S_FIN: begin
            cmd.fin_start = 1'b1;
            state_in      = S_FINW;
         end
         S_FINW: begin
            if (sts.fin_done) begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.load = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (cmd.load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;

`ifndef NO_ASSERTIONS
   a_load_valid: assert property (@(posedge clock) disable iff (reset)
      cmd.load |=> rsp_valid_ff) else $error("loaded response not presented");
   a_apply_once: assert property (@(posedge clock) disable iff (reset)
      cmd.apply |=> !cmd.apply && cmd.fin_start) else $error("apply not followed by final phase");
   a_capture_busy: assert property (@(posedge clock) disable iff (reset)
      cmd.capture |=> !req_ready) else $error("accepted a request while busy");
`endif
endmodule
`default_nettype wire

### rtl/tea_datapath.sv
// Arena pointers, temp tracking, alignment remainders and response registers.
`timescale 1ns / 1ps
`default_nettype none
module tea_datapath (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire tea_pkg::tea_cmd_type          cmd,
   output tea_pkg::tea_sts_type               sts,
   input  wire logic                          csr_we,
   input  wire logic                          csr_index,
   input  wire logic [tea_pkg::ADDR_W-1:0]    csr_wdata,
   input  wire logic [tea_pkg::REQ_W-1:0]     req_type,
   input  wire logic [tea_pkg::SIZE_W-1:0]    alloc_size,
   input  wire logic [tea_pkg::ALIGN_W-1:0]   align,
   input  wire logic [tea_pkg::ADDR_W-1:0]    buffer_addr,
   output logic [tea_pkg::STAT_W-1:0]         status,
   output logic [tea_pkg::ADDR_W-1:0]         result_addr,
   output logic [tea_pkg::SIZE_W-1:0]         persistent_used,
   output logic [tea_pkg::SIZE_W-1:0]         nonpersistent_used,
   output logic [tea_pkg::SIZE_W-1:0]         persistent_peak,
   output logic [tea_pkg::SIZE_W-1:0]         nonpersistent_peak,
   output logic [tea_pkg::SIZE_W-1:0]         free_bytes,
   output logic signed [tea_pkg::CNT_W-1:0]   temps_outstanding,
   output logic                               temps_clean
);
   import tea_pkg::*;

   function automatic logic [PTR_W-1:0] sat_size(input logic [SIZE_W-1:0] s);
      return (s > ARENA_MAX_BYTES) ? PTR_W'(ARENA_MAX_BYTES) : PTR_W'(s);
   endfunction

   function automatic logic [PTR_W-1:0] max_ptr(input logic [PTR_W-1:0] x,
                                                input logic [PTR_W-1:0] y);
      return (x > y) ? x : y;
   endfunction

   // Captured request
   logic [REQ_W-1:0]   type_ff;
   logic [SIZE_W-1:0]  size_ff;
   logic [ALIGN_W-1:0] align_ff;
   logic [ADDR_W-1:0]  baddr_ff;
   // Configuration and arena state
   logic [ADDR_W-1:0]  base_ff;
   logic [SIZE_W-1:0]  asize_ff;
   logic [PTR_W-1:0]   head_ff, temp_ff, tail_ff, hpeak_ff, tpeak_ff, tlow_ff;
   logic [CNT_W-1:0]   tcount_ff;
   logic [ADDR_W-1:0]  txor_ff;
   logic [STAT_W-1:0]  stat_ff;
   logic [ADDR_W-1:0]  addr_ff;
   // Response registers
   logic [STAT_W-1:0]  o_stat_ff;
   logic [ADDR_W-1:0]  o_addr_ff;
   logic [SIZE_W-1:0]  o_pused_ff, o_npused_ff, o_ppeak_ff, o_nppeak_ff, o_free_ff;
   logic [CNT_W-1:0]   o_count_ff;
   logic               o_clean_ff;

   logic [ALIGN_W-1:0] align_eff;
   logic [ADDR_W-1:0]  cfg_base;
   logic [SIZE_W-1:0]  cfg_size;
   logic [PTR_W-1:0]   cfg_end, end_w, base_w, size_w;
   logic [PTR_W-1:0]   op_dvd, op_down, op_up, op_new, dvd_a;
   logic               op_fail;
   logic [ALIGN_W-1:0] rem_a, rem_b;
   logic               done_a, done_b;
   logic [PTR_W-1:0]   fin_up, fin_down, free_w, np_w, npp_w;

   always_comb begin
      if (align == '0) begin
         align_eff = ALIGN_W'(1);
      end else if (align > ALIGN_MAX) begin
         align_eff = ALIGN_MAX;
      end else begin
         align_eff = align;
      end
   end

   assign cfg_base = (csr_index == CSR_BASE) ? csr_wdata : base_ff;
   assign cfg_size = (csr_index == CSR_SIZE) ? csr_wdata[SIZE_W-1:0] : asize_ff;
   assign cfg_end  = {1'b0, cfg_base} + sat_size(cfg_size);
   assign base_w   = {1'b0, base_ff};
   assign end_w    = base_w + sat_size(asize_ff);
   assign size_w   = PTR_W'(size_ff);

   // First remainder: the address that the request itself rounds.
   always_comb begin
      case (type_ff)
         REQ_PERSIST: op_dvd = tail_ff - size_w;
         REQ_TEMP:    op_dvd = temp_ff;
         default:     op_dvd = base_w;
      endcase
   end

   assign sts.op_div_req = ((type_ff == REQ_PERSIST) && (size_w <= tail_ff)) ||
                           (type_ff == REQ_TEMP) || (type_ff == REQ_RESIZE);
   assign sts.op_done    = done_a;
   assign sts.fin_done   = done_a & done_b;

   assign op_down = op_dvd - PTR_W'(rem_a);
   assign op_up   = (rem_a == '0) ? op_dvd : op_down + PTR_W'(align_ff);
   assign op_new  = op_up + size_w;
   assign op_fail = (op_up > tail_ff) || ((tail_ff - op_up) < size_w);

   assign dvd_a = cmd.fin_start ? temp_ff : op_dvd;

   tea_rem u_rem_a (
      .clock     (clock),
      .reset     (reset),
      .start     (cmd.op_start | cmd.fin_start),
      .dividend  (dvd_a),
      .divisor   (align_ff),
      .done      (done_a),
      .remainder (rem_a)
   );

   tea_rem u_rem_b (
      .clock     (clock),
      .reset     (reset),
      .start     (cmd.fin_start),
      .dividend  (tail_ff),
      .divisor   (align_ff),
      .done      (done_b),
      .remainder (rem_b)
   );

   // Free space between the aligned temp pointer and the aligned tail.
   assign fin_down = tail_ff - PTR_W'(rem_b);
   assign fin_up   = (rem_a == '0) ? temp_ff : temp_ff - PTR_W'(rem_a) + PTR_W'(align_ff);
   assign free_w   = (fin_down > fin_up) ? fin_down - fin_up : '0;
   assign np_w     = max_ptr(head_ff, temp_ff) - base_w;
   assign npp_w    = max_ptr(hpeak_ff, tpeak_ff) - base_w;

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         type_ff  <= req_type;
         size_ff  <= alloc_size;
         align_ff <= align_eff;
         baddr_ff <= buffer_addr;
      end
      if (cmd.load) begin
         o_stat_ff   <= stat_ff;
         o_addr_ff   <= addr_ff;
         o_pused_ff  <= SIZE_W'(end_w - tail_ff);
         o_npused_ff <= np_w[SIZE_W-1:0];
         o_ppeak_ff  <= SIZE_W'(end_w - tlow_ff);
         o_nppeak_ff <= npp_w[SIZE_W-1:0];
         o_free_ff   <= free_w[SIZE_W-1:0];
         o_count_ff  <= tcount_ff;
         o_clean_ff  <= (tcount_ff == '0) && (txor_ff == '0);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff   <= '0;
         asize_ff  <= ARENA_MAX_BYTES;
         head_ff   <= '0;
         temp_ff   <= '0;
         hpeak_ff  <= '0;
         tpeak_ff  <= '0;
         tail_ff   <= PTR_W'(ARENA_MAX_BYTES);
         tlow_ff   <= PTR_W'(ARENA_MAX_BYTES);
         tcount_ff <= '0;
         txor_ff   <= '0;
      end else if (csr_we) begin
         base_ff   <= cfg_base;
         asize_ff  <= cfg_size;
         head_ff   <= {1'b0, cfg_base};
         temp_ff   <= {1'b0, cfg_base};
         hpeak_ff  <= {1'b0, cfg_base};
         tpeak_ff  <= {1'b0, cfg_base};
         tail_ff   <= cfg_end;
         tlow_ff   <= cfg_end;
         tcount_ff <= '0;
         txor_ff   <= '0;
      end else if (cmd.apply) begin
         stat_ff <= ST_OK;
         addr_ff <= '0;
         case (type_ff)
            REQ_PERSIST: begin
               if (!sts.op_div_req || (op_down < head_ff)) begin
                  stat_ff <= ST_OOM;
               end else begin
                  tail_ff <= op_down;
                  if (op_down < tlow_ff) begin
                     tlow_ff <= op_down;
                  end
                  addr_ff <= op_down[ADDR_W-1:0];
               end
            end
            REQ_TEMP: begin
               if (op_fail) begin
                  stat_ff <= ST_OOM;
               end else begin
                  temp_ff   <= op_new;
                  tpeak_ff  <= max_ptr(tpeak_ff, op_new);
                  txor_ff   <= txor_ff ^ op_up[ADDR_W-1:0];
                  tcount_ff <= tcount_ff + 1'b1;
                  addr_ff   <= op_up[ADDR_W-1:0];
               end
            end
            REQ_FREE: begin
               txor_ff   <= txor_ff ^ baddr_ff;
               tcount_ff <= tcount_ff - 1'b1;
            end
            REQ_RESET: begin
               if ((tcount_ff != '0) || (txor_ff != '0)) begin
                  stat_ff <= ST_TEMPS;
               end else begin
                  temp_ff  <= head_ff;
                  tpeak_ff <= max_ptr(tpeak_ff, head_ff);
               end
            end
            REQ_RESIZE: begin
               if ((head_ff != temp_ff) || (baddr_ff != op_up[ADDR_W-1:0])) begin
                  stat_ff <= ST_HEAD;
               end else if (op_fail) begin
                  stat_ff <= ST_OOM;
               end else begin
                  head_ff  <= op_new;
                  hpeak_ff <= max_ptr(hpeak_ff, op_new);
                  temp_ff  <= op_new;
                  tpeak_ff <= max_ptr(tpeak_ff, op_new);
                  addr_ff  <= op_up[ADDR_W-1:0];
               end
            end
            default: begin
            end
         endcase
      end
   end

   assign status             = o_stat_ff;
   assign result_addr        = o_addr_ff;
   assign persistent_used    = o_pused_ff;
   assign nonpersistent_used = o_npused_ff;
   assign persistent_peak    = o_ppeak_ff;
   assign nonpersistent_peak = o_nppeak_ff;
   assign free_bytes         = o_free_ff;
   assign temps_outstanding  = o_count_ff;
   assign temps_clean        = o_clean_ff;

`ifndef NO_ASSERTIONS
   a_tail_above_head: assert property (@(posedge clock) disable iff (reset)
      cmd.load |-> (tail_ff >= head_ff)) else $error("tail pointer fell below head");
   a_low_mark: assert property (@(posedge clock) disable iff (reset)
      cmd.load |-> (tlow_ff <= tail_ff)) else $error("lowest tail above current tail");
   a_rem_range: assert property (@(posedge clock) disable iff (reset)
      done_a |-> (rem_a < align_ff)) else $error("remainder not below alignment");
`endif
endmodule
`default_nettype wire

### rtl/two_ended_arena_allocator_core.sv
// Top level of the two-ended arena allocator: controller, datapath and channel wiring.
//
// One arena is managed: persistent buffers are taken downward from the top, the
// resizable head buffer and stacked temporary buffers grow upward from the base.
// Requests arrive on req_chan (valid/ready); each request produces exactly one
// response on rsp_chan carrying status, address, usage, peaks and free space.
// arena_base (index 0) and arena_size (index 1) are written on the csr_ port;
// a write re-initializes every pointer, peak and temp counter.
// Temp and resize requests, and persistent requests that fit below the tail
// address, take one alignment rounding more than the others between acceptance
// and response. Each alignment rounding runs 33 steps in a bit-serial
// remainder unit; the final free-space figure needs two roundings, done in
// parallel by two units.
// Throughput is one request at a time; the next request is accepted as soon as
// the response of the previous one has been loaded into the output register,
// even while that response still waits for rsp ready.
// If the receiver stalls, a finished response waits inside the block until the
// output register is free. Reset (synchronous) restores base 0 and a 16 MiB arena.
`timescale 1ns / 1ps
`default_nettype none
module two_ended_arena_allocator_core (
   input  wire logic                       clock,
   input  wire logic                       reset,
   tea_req_if.sink                         req_chan,
   tea_rsp_if.source                       rsp_chan,
   input  wire logic                       csr_we,
   input  wire logic                       csr_index,
   input  wire logic [tea_pkg::ADDR_W-1:0] csr_wdata
);
   import tea_pkg::*;

   tea_cmd_type cmd;
   tea_sts_type sts;

   tea_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   tea_datapath u_datapath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .sts                (sts),
      .csr_we             (csr_we),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata),
      .req_type           (req_chan.req_type),
      .alloc_size         (req_chan.alloc_size),
      .align              (req_chan.align),
      .buffer_addr        (req_chan.buffer_addr),
      .status             (rsp_chan.status),
      .result_addr        (rsp_chan.result_addr),
      .persistent_used    (rsp_chan.persistent_used),
      .nonpersistent_used (rsp_chan.nonpersistent_used),
      .persistent_peak    (rsp_chan.persistent_peak),
      .nonpersistent_peak (rsp_chan.nonpersistent_peak),
      .free_bytes         (rsp_chan.free_bytes),
      .temps_outstanding  (rsp_chan.temps_outstanding),
      .temps_clean        (rsp_chan.temps_clean)
   );

endmodule
`default_nettype wire
